// ===== sv/pgtm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgtm_pkg
// Types and constants shared by the page table manager: table pool sizing,
// entry layout, request and status codes, configuration indexes, and the
// control groups passed between the top level and the walker.
// ----------------------------------------------------------------------------
package pgtm_pkg;

    localparam int TABLE_POOL    = 64;
    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TBL_W         = $clog2(TABLE_POOL);
    localparam int ADDR_W        = TBL_W + IDX_W;
    localparam int STORE_DEPTH   = TABLE_POOL * TABLE_ENTRIES;

    localparam int PAGE_W     = 40;
    localparam int VPAGE_W    = 36;
    localparam int NF_W       = 7;
    localparam int ENTRY_W    = PAGE_W + 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [NF_W-1:0] FIRST_FREE_RESET = NF_W'(1);
    localparam logic [1:0]      LEAF_LEVEL       = 2'd3;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_TABLE_BASE = 1'b0,
        CFG_FIRST_FREE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        WS_CLEAR,
        WS_IDLE,
        WS_READ,
        WS_EVAL,
        WS_FIN
    } t_walk_state;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              writable;
        logic              present;
    } t_entry;

    typedef struct packed {
        logic [PAGE_W-1:0] base;
        logic              nf_load;
        logic [NF_W-1:0]   nf_value;
    } t_cfg_ctl;

    typedef struct packed {
        logic            clearing;
        logic [NF_W-1:0] next_free;
    } t_walk_stat;

endpackage
`default_nettype wire

// ===== sv/pgtm_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgtm_req_if
// Request channel: operation, virtual page and physical page, with a
// valid/ready transfer.
// ----------------------------------------------------------------------------
interface pgtm_req_if;
    logic                         valid;
    logic                         ready;
    pgtm_pkg::t_op                op;
    logic [pgtm_pkg::VPAGE_W-1:0] virt_page;
    logic [pgtm_pkg::PAGE_W-1:0]  phys_page;

    modport source (output valid, output op, output virt_page, output phys_page,
                    input ready);
    modport sink   (input valid, input op, input virt_page, input phys_page,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/pgtm_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgtm_rsp_if
// Result channel: translated page, found flag and status, with a valid/ready
// transfer.
// ----------------------------------------------------------------------------
interface pgtm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pgtm_pkg::PAGE_W-1:0] result_page;
    logic                        found;
    pgtm_pkg::t_status           status;

    modport source (output valid, output result_page, output found, output status,
                    input ready);
    modport sink   (input valid, input result_page, input found, input status,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/pgtm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgtm_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module pgtm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/pgtm_addsub.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgtm_addsub
// Shared page-number adder: forms a new link page from base plus counter,
// or recovers a pool table number from a link page minus base.
// ----------------------------------------------------------------------------
module pgtm_addsub (
    input  wire logic [pgtm_pkg::PAGE_W-1:0] i_a,
    input  wire logic [pgtm_pkg::PAGE_W-1:0] i_b,
    input  wire logic                        i_sub,
    output logic      [pgtm_pkg::PAGE_W-1:0] o_y
);
    assign o_y = i_sub ? (i_a - i_b) : (i_a + i_b);
endmodule
`default_nettype wire

// ===== sv/pgtm_walk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgtm_walk
// Table walk sequencer: clears the table store after reset, then walks up to
// four levels of each request one read and evaluate step at a time, linking
// fresh tables on map, and registers the result for the output transfer.
// ----------------------------------------------------------------------------
module pgtm_walk (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pgtm_pkg::t_cfg_ctl   i_cfg,
    pgtm_req_if.sink                  i_req,
    pgtm_rsp_if.source                o_rsp,
    output pgtm_pkg::t_walk_stat      o_stat
);
    pgtm_pkg::t_walk_state r_state, n_state;
    logic [pgtm_pkg::ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    pgtm_pkg::t_op                r_op, n_op;
    logic [pgtm_pkg::VPAGE_W-1:0] r_vpage, n_vpage;
    logic [pgtm_pkg::PAGE_W-1:0]  r_ppage, n_ppage;
    logic [1:0]                   r_level, n_level;
    logic [pgtm_pkg::TBL_W-1:0]   r_tbl, n_tbl;
    logic [pgtm_pkg::NF_W-1:0]    r_nf, n_nf;
    logic [pgtm_pkg::PAGE_W-1:0]  r_res_page, n_res_page;
    logic                         r_res_found, n_res_found;
    pgtm_pkg::t_status            r_res_status, n_res_status;
    logic                         r_ov, n_ov;
    logic [pgtm_pkg::PAGE_W-1:0]  r_o_page, n_o_page;
    logic                         r_o_found, n_o_found;
    pgtm_pkg::t_status            r_o_status, n_o_status;

    logic [pgtm_pkg::IDX_W-1:0]   lvl_idx;
    logic [pgtm_pkg::ADDR_W-1:0]  walk_addr;
    logic                         ram_we;
    logic [pgtm_pkg::ADDR_W-1:0]  ram_waddr;
    pgtm_pkg::t_entry             ram_wdata;
    logic [pgtm_pkg::ENTRY_W-1:0] ram_rdata;
    pgtm_pkg::t_entry             rd_entry;
    logic [pgtm_pkg::PAGE_W-1:0]  au_a, au_b, au_y;
    logic                         au_sub;
    logic                         nf_full;
    logic                         link_ok;

    always_comb begin
        unique case (r_level)
            2'd0:    lvl_idx = r_vpage[4*pgtm_pkg::IDX_W-1:3*pgtm_pkg::IDX_W];
            2'd1:    lvl_idx = r_vpage[3*pgtm_pkg::IDX_W-1:2*pgtm_pkg::IDX_W];
            2'd2:    lvl_idx = r_vpage[2*pgtm_pkg::IDX_W-1:pgtm_pkg::IDX_W];
            default: lvl_idx = r_vpage[pgtm_pkg::IDX_W-1:0];
        endcase
    end

    assign walk_addr = {r_tbl, lvl_idx};
    assign rd_entry  = pgtm_pkg::t_entry'(ram_rdata);

    pgtm_ram #(
        .DEPTH (pgtm_pkg::STORE_DEPTH),
        .WIDTH (pgtm_pkg::ENTRY_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (walk_addr),
        .o_rdata (ram_rdata)
    );

    assign au_sub = rd_entry.present;
    assign au_a   = rd_entry.present ? rd_entry.page : i_cfg.base;
    assign au_b   = rd_entry.present ? i_cfg.base : pgtm_pkg::PAGE_W'(r_nf);

    pgtm_addsub u_addsub (
        .i_a   (au_a),
        .i_b   (au_b),
        .i_sub (au_sub),
        .o_y   (au_y)
    );

    assign nf_full = 32'(r_nf) >= 32'(pgtm_pkg::TABLE_POOL);
    assign link_ok = au_y < pgtm_pkg::PAGE_W'(pgtm_pkg::TABLE_POOL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pgtm_pkg::WS_CLEAR;
            r_clr_addr <= '0;
            r_nf       <= pgtm_pkg::FIRST_FREE_RESET;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_nf       <= n_nf;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_vpage      <= n_vpage;
        r_ppage      <= n_ppage;
        r_level      <= n_level;
        r_tbl        <= n_tbl;
        r_res_page   <= n_res_page;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_o_page     <= n_o_page;
        r_o_found    <= n_o_found;
        r_o_status   <= n_o_status;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op         = r_op;
        n_vpage      = r_vpage;
        n_ppage      = r_ppage;
        n_level      = r_level;
        n_tbl        = r_tbl;
        n_nf         = r_nf;
        n_res_page   = r_res_page;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_ov         = r_ov && !o_rsp.ready;
        n_o_page     = r_o_page;
        n_o_found    = r_o_found;
        n_o_status   = r_o_status;
        ram_we       = 1'b0;
        ram_waddr    = walk_addr;
        ram_wdata    = '0;

        unique case (r_state)
            pgtm_pkg::WS_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = pgtm_pkg::WS_IDLE;
                end
            end
            pgtm_pkg::WS_IDLE: begin
                if (i_req.valid) begin
                    n_op         = i_req.op;
                    n_vpage      = i_req.virt_page;
                    n_ppage      = i_req.phys_page;
                    n_level      = '0;
                    n_tbl        = '0;
                    n_res_page   = '0;
                    n_res_found  = 1'b0;
                    n_res_status = pgtm_pkg::ST_OK;
                    n_state      = (i_req.op == pgtm_pkg::OP_NOP) ? pgtm_pkg::WS_FIN
                                                                  : pgtm_pkg::WS_READ;
                end
            end
            pgtm_pkg::WS_READ: begin
                n_state = pgtm_pkg::WS_EVAL;
            end
            pgtm_pkg::WS_EVAL: begin
                if (r_level != pgtm_pkg::LEAF_LEVEL) begin
                    if (!rd_entry.present) begin
                        if (r_op != pgtm_pkg::OP_MAP) begin
                            n_state = pgtm_pkg::WS_FIN;
                        end else if (nf_full) begin
                            n_res_status = pgtm_pkg::ST_EXHAUSTED;
                            n_state      = pgtm_pkg::WS_FIN;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = '{page: au_y, writable: 1'b1, present: 1'b1};
                            n_tbl     = r_nf[pgtm_pkg::TBL_W-1:0];
                            n_nf      = r_nf + 1'b1;
                            n_level   = r_level + 1'b1;
                            n_state   = pgtm_pkg::WS_READ;
                        end
                    end else if (!link_ok) begin
                        if (r_op == pgtm_pkg::OP_MAP) begin
                            n_res_status = pgtm_pkg::ST_EXHAUSTED;
                        end
                        n_state = pgtm_pkg::WS_FIN;
                    end else begin
                        n_tbl   = au_y[pgtm_pkg::TBL_W-1:0];
                        n_level = r_level + 1'b1;
                        n_state = pgtm_pkg::WS_READ;
                    end
                end else begin
                    unique case (r_op)
                        pgtm_pkg::OP_MAP: begin
                            if (rd_entry.present) begin
                                n_res_status = pgtm_pkg::ST_PRESENT;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = '{page: r_ppage, writable: 1'b1, present: 1'b1};
                            end
                        end
                        pgtm_pkg::OP_UNMAP: begin
                            ram_we = 1'b1;
                        end
                        pgtm_pkg::OP_XLATE: begin
                            if (rd_entry.present) begin
                                n_res_page  = rd_entry.page;
                                n_res_found = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = pgtm_pkg::WS_FIN;
                end
            end
            pgtm_pkg::WS_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_page   = r_res_page;
                    n_o_found  = r_res_found;
                    n_o_status = r_res_status;
                    n_state    = pgtm_pkg::WS_IDLE;
                end
            end
            default: begin
                n_state = pgtm_pkg::WS_IDLE;
            end
        endcase

        if (i_cfg.nf_load) begin
            n_nf = i_cfg.nf_value;
        end
    end

    assign i_req.ready       = (r_state == pgtm_pkg::WS_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.result_page = r_o_page;
    assign o_rsp.found       = r_o_found;
    assign o_rsp.status      = r_o_status;

    assign o_stat.clearing  = (r_state == pgtm_pkg::WS_CLEAR);
    assign o_stat.next_free = r_nf;
endmodule
`default_nettype wire

// ===== sv/four_level_page_table_manager.sv =====
// Four-level page table manager. Requests (map, unmap, translate, no-op) are
// served one at a time; each yields exactly one result. After reset the table
// store (64 tables of 512 entries) is swept to zero, one entry per cycle,
// during which no request is taken; configuration writes are taken
// throughout. A request is accepted, then each level visited is read from
// the single store port and evaluated through the shared page adder, and
// the result is handed to the output register; a walk may stop early, and
// a no-op skips the walk. The output register lets the next request be
// accepted while a result waits to be taken; a second finished result holds
// the walker until the first is taken.
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_manager
// Top level: configuration registers, table walk sequencer and checks.
// ----------------------------------------------------------------------------
module four_level_page_table_manager (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire pgtm_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [pgtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pgtm_req_if.sink                             i_req,
    pgtm_rsp_if.source                           o_rsp
);
    logic [pgtm_pkg::PAGE_W-1:0] r_base, n_base;
    logic [pgtm_pkg::NF_W-1:0]   cfg_ff;
    pgtm_pkg::t_cfg_ctl          cfg;
    pgtm_pkg::t_walk_stat        stat;

    always_comb begin
        n_base = r_base;
        if (i_cfg_we && i_cfg_index == pgtm_pkg::CFG_TABLE_BASE) begin
            n_base = i_cfg_data[pgtm_pkg::PAGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else begin
            r_base <= n_base;
        end
    end

    assign cfg_ff = (i_cfg_data[pgtm_pkg::NF_W-1:0] == '0) ? pgtm_pkg::FIRST_FREE_RESET
                                                            : i_cfg_data[pgtm_pkg::NF_W-1:0];

    assign cfg.base     = r_base;
    assign cfg.nf_load  = i_cfg_we && (i_cfg_index == pgtm_pkg::CFG_FIRST_FREE);
    assign cfg.nf_value = cfg_ff;

    pgtm_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_stat  (stat)
    );

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !i_req.ready)
        else $error("request taken during store clear");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken while walking");

    a_counter_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> (stat.next_free >= $past(stat.next_free)))
        else $error("allocation counter moved back without a load");

    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.result_page == '0))
        else $error("page returned without a hit");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> (o_rsp.status == pgtm_pkg::ST_OK))
        else $error("hit reported with error status");
endmodule
`default_nettype wire

// ===== sim/tb_four_level_page_table_manager.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_manager
// Self-checking bench for the page table manager. A scoreboard keeps its own
// copy of the table pool, base page and allocation counter, and works out the
// result of every accepted request. Each returned result is checked field by
// field against the oldest prediction. Stimulus runs in phases with different
// base and free-table settings, mixing map, unmap, translate and no-op
// requests over a small set of hot indices so that walks go deep.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_manager;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int QUIET_LIMIT = 200000;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [pgtm_pkg::PAGE_W-1:0] page;
        logic                        found;
        pgtm_pkg::t_status           status;
    } t_xlate_result;

    class pt_scoreboard;
        pgtm_pkg::t_entry            tables [pgtm_pkg::STORE_DEPTH];
        logic [pgtm_pkg::PAGE_W-1:0] base_page;
        logic [pgtm_pkg::NF_W-1:0]   next_free;
        t_xlate_result               pending [$];
        int                          errors;
        int                          checked;

        function new();
            foreach (tables[i]) tables[i] = '0;
            base_page = '0;
            next_free = pgtm_pkg::FIRST_FREE_RESET;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_reg(pgtm_pkg::t_cfg_idx idx,
                                logic [pgtm_pkg::CFG_DATA_W-1:0] data);
            logic [pgtm_pkg::NF_W-1:0] ff;
            ff = data[pgtm_pkg::NF_W-1:0];
            if (idx == pgtm_pkg::CFG_TABLE_BASE) begin
                base_page = data[pgtm_pkg::PAGE_W-1:0];
            end else begin
                next_free = (ff == '0) ? pgtm_pkg::FIRST_FREE_RESET : ff;
            end
        endfunction

        function int slot_of(int tbl, logic [pgtm_pkg::VPAGE_W-1:0] vp, int lvl);
            return tbl * pgtm_pkg::TABLE_ENTRIES
                   + int'(vp[pgtm_pkg::VPAGE_W-1-pgtm_pkg::IDX_W*lvl -: pgtm_pkg::IDX_W]);
        endfunction

        function bit follow(pgtm_pkg::t_entry e, output int tbl);
            logic [pgtm_pkg::PAGE_W-1:0] off;
            off = e.page - base_page;
            tbl = 0;
            if (off >= pgtm_pkg::PAGE_W'(pgtm_pkg::TABLE_POOL)) return 1'b0;
            tbl = int'(off);
            return 1'b1;
        endfunction

        function bit find_leaf(logic [pgtm_pkg::VPAGE_W-1:0] vp, output int tbl);
            int lvl;
            int t;
            t   = 0;
            tbl = 0;
            for (lvl = 0; lvl < int'(pgtm_pkg::LEAF_LEVEL); lvl++) begin
                if (!tables[slot_of(t, vp, lvl)].present) return 1'b0;
                if (!follow(tables[slot_of(t, vp, lvl)], t)) return 1'b0;
            end
            tbl = t;
            return 1'b1;
        endfunction

        function pgtm_pkg::t_status map_page(logic [pgtm_pkg::VPAGE_W-1:0] vp,
                                             logic [pgtm_pkg::PAGE_W-1:0] pp);
            int lvl;
            int t;
            int slot;
            t = 0;
            for (lvl = 0; lvl < int'(pgtm_pkg::LEAF_LEVEL); lvl++) begin
                slot = slot_of(t, vp, lvl);
                if (!tables[slot].present) begin
                    if (next_free >= pgtm_pkg::NF_W'(pgtm_pkg::TABLE_POOL)) begin
                        return pgtm_pkg::ST_EXHAUSTED;
                    end
                    tables[slot].page     = base_page + pgtm_pkg::PAGE_W'(next_free);
                    tables[slot].writable = 1'b1;
                    tables[slot].present  = 1'b1;
                    next_free++;
                end
                if (!follow(tables[slot], t)) return pgtm_pkg::ST_EXHAUSTED;
            end
            slot = slot_of(t, vp, int'(pgtm_pkg::LEAF_LEVEL));
            if (tables[slot].present) return pgtm_pkg::ST_PRESENT;
            tables[slot].page     = pp;
            tables[slot].writable = 1'b1;
            tables[slot].present  = 1'b1;
            return pgtm_pkg::ST_OK;
        endfunction

        function void note_request(pgtm_pkg::t_op op, logic [pgtm_pkg::VPAGE_W-1:0] vp,
                                   logic [pgtm_pkg::PAGE_W-1:0] pp);
            t_xlate_result r;
            int t;
            int leaf;
            leaf     = int'(pgtm_pkg::LEAF_LEVEL);
            r.page   = '0;
            r.found  = 1'b0;
            r.status = pgtm_pkg::ST_OK;
            case (op)
                pgtm_pkg::OP_MAP: begin
                    r.status = map_page(vp, pp);
                end
                pgtm_pkg::OP_UNMAP: begin
                    if (find_leaf(vp, t)) tables[slot_of(t, vp, leaf)] = '0;
                end
                pgtm_pkg::OP_XLATE: begin
                    if (find_leaf(vp, t)) begin
                        if (tables[slot_of(t, vp, leaf)].present) begin
                            r.page  = tables[slot_of(t, vp, leaf)].page;
                            r.found = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [pgtm_pkg::PAGE_W-1:0] page, logic found,
                                   pgtm_pkg::t_status status);
            t_xlate_result want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, %s %h found %b status %0d",
                         $time, "actual page", page, found, status);
                return;
            end
            want = pending.pop_front();
            if (page !== want.page) begin
                errors++;
                $display("%0t: result_page mismatch: expected %h, actual %h",
                         $time, want.page, page);
            end
            if (found !== want.found) begin
                errors++;
                $display("%0t: found mismatch: expected %b, actual %b",
                         $time, want.found, found);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    pgtm_pkg::t_cfg_idx              i_cfg_index;
    logic [pgtm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    pgtm_req_if req_ch ();
    pgtm_rsp_if rsp_ch ();

    pt_scoreboard sb = new();

    bit                           idle_on;
    logic [pgtm_pkg::IDX_W-1:0]   hot_idx [3][3];
    logic [pgtm_pkg::VPAGE_W-1:0] mapped_vps [$];

    four_level_page_table_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                sb.note_request(req_ch.op, req_ch.virt_page, req_ch.phys_page);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                sb.check_result(rsp_ch.result_page, rsp_ch.found, rsp_ch.status);
            end
        end
    end

    // result side: random stalls, plus one long hold to back the block up
    initial begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sb.checked >= 300) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end else if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) break;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_req(pgtm_pkg::t_op op, logic [pgtm_pkg::VPAGE_W-1:0] vp,
                            logic [pgtm_pkg::PAGE_W-1:0] pp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.virt_page <= vp;
        req_ch.phys_page <= pp;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_config(logic [pgtm_pkg::PAGE_W-1:0] base,
                              logic [pgtm_pkg::NF_W-1:0] ff);
        logic [pgtm_pkg::CFG_DATA_W-1:0] d;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pgtm_pkg::CFG_TABLE_BASE;
        i_cfg_data  <= pgtm_pkg::CFG_DATA_W'(base);
        @(posedge i_clk);
        sb.write_reg(pgtm_pkg::CFG_TABLE_BASE, pgtm_pkg::CFG_DATA_W'(base));
        d = '0;
        if ($urandom_range(0, 1) == 1) d = pgtm_pkg::CFG_DATA_W'({$urandom(), $urandom()});
        d[pgtm_pkg::NF_W-1:0] = ff;
        i_cfg_index <= pgtm_pkg::CFG_FIRST_FREE;
        i_cfg_data  <= d;
        @(posedge i_clk);
        sb.write_reg(pgtm_pkg::CFG_FIRST_FREE, d);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain(int extra);
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic pick_hot();
        int lvl;
        for (lvl = 0; lvl < 3; lvl++) begin
            hot_idx[lvl][0] = ($urandom_range(0, 1) == 1) ? '0
                                                         : pgtm_pkg::IDX_W'($urandom());
            hot_idx[lvl][1] = ($urandom_range(0, 1) == 1) ? '1
                                                         : pgtm_pkg::IDX_W'($urandom());
            hot_idx[lvl][2] = pgtm_pkg::IDX_W'($urandom());
        end
    endtask

    function automatic logic [pgtm_pkg::VPAGE_W-1:0] hot_vpage();
        logic [pgtm_pkg::VPAGE_W-1:0] vp;
        int lvl;
        vp = pgtm_pkg::VPAGE_W'({$urandom(), $urandom()});
        for (lvl = 0; lvl < 3; lvl++) begin
            if ($urandom_range(0, 15) != 0) begin
                vp[pgtm_pkg::VPAGE_W-1-pgtm_pkg::IDX_W*lvl -: pgtm_pkg::IDX_W] =
                    hot_idx[lvl][$urandom_range(0, 2)];
            end
        end
        return vp;
    endfunction

    task automatic random_req();
        int r;
        pgtm_pkg::t_op op;
        logic [pgtm_pkg::VPAGE_W-1:0] vp;
        logic [pgtm_pkg::PAGE_W-1:0] pp;
        r = $urandom_range(0, 99);
        if (r < 40) op = pgtm_pkg::OP_MAP;
        else if (r < 70) op = pgtm_pkg::OP_XLATE;
        else if (r < 90) op = pgtm_pkg::OP_UNMAP;
        else op = pgtm_pkg::OP_NOP;
        if (mapped_vps.size() > 0 && $urandom_range(0, 1) == 1) begin
            vp = mapped_vps[$urandom_range(0, mapped_vps.size() - 1)];
        end else begin
            vp = hot_vpage();
        end
        pp = pgtm_pkg::PAGE_W'({$urandom(), $urandom()});
        if (op == pgtm_pkg::OP_MAP) begin
            mapped_vps.push_back(vp);
            if (mapped_vps.size() > 48) void'(mapped_vps.pop_front());
        end
        send_req(op, vp, pp);
    endtask

    task automatic directed_reqs();
        logic [pgtm_pkg::VPAGE_W-1:0] mixed;
        mixed = {9'h155, 9'h0aa, 9'h155, 9'h0aa};
        send_req(pgtm_pkg::OP_XLATE, '0, '0);
        send_req(pgtm_pkg::OP_UNMAP, '0, '0);
        send_req(pgtm_pkg::OP_MAP,   '0, '0);
        send_req(pgtm_pkg::OP_XLATE, '0, '1);
        send_req(pgtm_pkg::OP_MAP,   '1, '1);
        send_req(pgtm_pkg::OP_XLATE, '1, '0);
        send_req(pgtm_pkg::OP_MAP,   '0, 40'h55_5555_5555);
        send_req(pgtm_pkg::OP_MAP,   pgtm_pkg::VPAGE_W'(1), 40'haa_aaaa_aaaa);
        send_req(pgtm_pkg::OP_XLATE, pgtm_pkg::VPAGE_W'(1), '0);
        send_req(pgtm_pkg::OP_UNMAP, '0, '1);
        send_req(pgtm_pkg::OP_XLATE, '0, '0);
        send_req(pgtm_pkg::OP_UNMAP, '0, '0);
        send_req(pgtm_pkg::OP_MAP,   '0, 40'h12_3456_789a);
        send_req(pgtm_pkg::OP_XLATE, '0, '0);
        send_req(pgtm_pkg::OP_NOP,   '1, '1);
        send_req(pgtm_pkg::OP_NOP,   '0, '0);
        send_req(pgtm_pkg::OP_MAP,   36'h8_0000_0000, 40'h80_0000_0000);
        send_req(pgtm_pkg::OP_XLATE, 36'h8_0000_0000, '0);
        send_req(pgtm_pkg::OP_MAP,   mixed, 40'h0f_0f0f_0f0f);
        send_req(pgtm_pkg::OP_XLATE, mixed, '0);
        send_req(pgtm_pkg::OP_UNMAP, '1, '0);
        send_req(pgtm_pkg::OP_XLATE, '1, '0);
    endtask

    function automatic logic [pgtm_pkg::PAGE_W-1:0] phase_base(int phase,
                                                               logic [pgtm_pkg::PAGE_W-1:0] home);
        case (phase)
            2, 3:    return '1;
            6:       return '0;
            default: return home;
        endcase
    endfunction

    function automatic logic [pgtm_pkg::NF_W-1:0] phase_first_free(int phase);
        case (phase)
            1:       return pgtm_pkg::NF_W'(33);
            3:       return '0;
            4:       return pgtm_pkg::NF_W'(pgtm_pkg::TABLE_POOL);
            5:       return '1;
            6:       return pgtm_pkg::NF_W'(2);
            7:       return pgtm_pkg::NF_W'($urandom_range(1, pgtm_pkg::TABLE_POOL));
            default: return pgtm_pkg::FIRST_FREE_RESET;
        endcase
    endfunction

    initial begin
        logic [pgtm_pkg::PAGE_W-1:0] home_base;
        int phase;
        int n;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= pgtm_pkg::CFG_TABLE_BASE;
        i_cfg_data       <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.op        <= pgtm_pkg::OP_NOP;
        req_ch.virt_page <= '0;
        req_ch.phys_page <= '0;
        idle_on   = 1'b1;
        home_base = pgtm_pkg::PAGE_W'({$urandom(), $urandom()});
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) drain(SETTLE);
            idle_on = (phase != PHASES - 1);
            pick_hot();
            set_config(phase_base(phase, home_base), phase_first_free(phase));
            if (phase == 0) directed_reqs();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase != PHASES - 1 && n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
                random_req();
            end
            req_ch.valid <= 1'b0;
        end
        drain(2 * SETTLE);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pgtm_pkg.sv
sv/pgtm_req_if.sv
sv/pgtm_rsp_if.sv
sv/pgtm_ram.sv
sv/pgtm_addsub.sv
sv/pgtm_walk.sv
sv/four_level_page_table_manager.sv
sim/tb_four_level_page_table_manager.sv
